[hdl/mwrms_pkg.sv]
`timescale 1ns / 1ps

package mwrms_pkg;

    // fixed field widths of the ports
    localparam int CH_FIELD_W     = 4;
    localparam int SAMPLE_FIELD_W = 16;
    localparam int RMS_W          = 16;

    // default configuration
    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_WINDOW_LEN  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

[hdl/moving_window_rms.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_channel, i_sample
// output   | out       | o_out_valid / i_out_ready  | o_out_channel, o_rms_value
//
// One request at a time: the ring read-modify-write runs after acceptance, followed by
// the bit-serial square root, scaled by WINDOW_LEN; the result is then loaded into the
// output register, and the next request is taken only after that. Reset (i_rst_n low,
// synchronous) empties the output register and marks every channel record unwritten;
// ring entries of a channel that has not yet wrapped read as zero. A result held in the
// output register does not stop the next request being accepted; only a second finished
// result waits for the register to drain.

module moving_window_rms #(
    parameter int CHANNELS    = mwrms_pkg::DEF_CHANNELS,
    parameter int WINDOW_LEN  = mwrms_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = mwrms_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic        [mwrms_pkg::CH_FIELD_W-1:0]     i_channel,
    input  logic signed [mwrms_pkg::SAMPLE_FIELD_W-1:0] i_sample,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic        [mwrms_pkg::CH_FIELD_W-1:0]     o_out_channel,
    output logic        [mwrms_pkg::RMS_W-1:0]          o_rms_value
);

    localparam int SB       = SAMPLE_BITS;
    localparam int EXT_W    = (SB > mwrms_pkg::SAMPLE_FIELD_W) ? SB : mwrms_pkg::SAMPLE_FIELD_W;
    localparam int SQ_W     = 2 * SB - 1;
    localparam int LOGW     = $clog2(WINDOW_LEN);
    localparam int SUM_W    = SQ_W + LOGW;
    localparam int D_W      = SUM_W + 2;
    localparam int POS_W    = (LOGW > 0) ? LOGW : 1;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX_W    = (CH_IDX_W > mwrms_pkg::CH_FIELD_W) ? CH_IDX_W
                                                                 : mwrms_pkg::CH_FIELD_W;
    localparam int RING_D   = CHANNELS * WINDOW_LEN;
    localparam int ADDR_W   = $clog2(RING_D);
    localparam int RT_W     = SB;
    localparam int RTX_W    = (RT_W > mwrms_pkg::RMS_W) ? RT_W : mwrms_pkg::RMS_W;
    localparam int CNT_W    = $clog2(RT_W + 1);
    localparam logic [D_W-1:0] B_INIT = D_W'(WINDOW_LEN) << (2 * RT_W - 2);

    typedef struct packed {
        logic             wrap;
        logic [POS_W-1:0] pos;
        logic [SUM_W-1:0] sum;
    } t_chan_st;

    mwrms_pkg::t_state r_state, n_state;

    // storage
    logic [SQ_W-1:0]  r_ring [RING_D];
    t_chan_st         r_chan_mem [CHANNELS];
    logic [CHANNELS-1:0] r_chan_vld;

    // working registers
    logic [mwrms_pkg::CH_FIELD_W-1:0] r_ch;
    logic [SB-1:0]     r_mag;
    t_chan_st          r_cst_rd;
    t_chan_st          r_cur;
    logic [SQ_W-1:0]   r_ring_rd;
    logic [SQ_W-1:0]   r_sq;
    logic [ADDR_W-1:0] r_addr;
    logic [SUM_W-1:0]  r_e;
    logic [D_W-1:0]    r_a;
    logic [D_W-1:0]    r_b;
    logic [RT_W-1:0]   r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_vld;
    logic [mwrms_pkg::CH_FIELD_W-1:0] r_out_ch;
    logic [mwrms_pkg::RMS_W-1:0]      r_out_rms;

    // combinational
    logic              in_acc;
    logic              ch_ok;
    logic [CHX_W-1:0]  in_ch_ext, cur_ch_ext;
    logic [CH_IDX_W-1:0] in_idx, cur_idx;
    logic [EXT_W-1:0]  raw_ext;
    logic [SB-1:0]     raw, mag;
    t_chan_st          cst;
    logic [ADDR_W-1:0] ring_addr;
    logic [2*SB-1:0]   mag_w, prod;
    logic [SQ_W-1:0]   old_sq;
    logic [SUM_W-1:0]  new_sum;
    logic              last_pos;
    t_chan_st          upd_st;
    logic [D_W-1:0]    sq_trial, sq_acc;
    logic              sq_ge;
    logic [RTX_W-1:0]  root_ext;
    logic [mwrms_pkg::RMS_W-1:0] rms;
    logic              out_load;
    logic              out_free;

    assign o_in_ready    = (r_state == mwrms_pkg::ST_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign ch_ok         = ({28'd0, i_channel} < 32'(CHANNELS));

    assign in_ch_ext     = CHX_W'(i_channel);
    assign in_idx        = in_ch_ext[CH_IDX_W-1:0];
    assign cur_ch_ext    = CHX_W'(r_ch);
    assign cur_idx       = cur_ch_ext[CH_IDX_W-1:0];

    // take the magnitude of the low SAMPLE_BITS bits as a two's complement value
    assign raw_ext       = EXT_W'($unsigned(i_sample));
    assign raw           = raw_ext[SB-1:0];
    assign mag           = raw[SB-1] ? SB'(~raw + SB'(1)) : raw;

    // unwritten channel record reads as zero
    assign cst           = r_chan_vld[cur_idx] ? r_cst_rd : '0;
    assign ring_addr     = ADDR_W'(32'(cur_idx) * WINDOW_LEN) + ADDR_W'(cst.pos);
    assign mag_w         = (2 * SB)'(r_mag);
    assign prod          = mag_w * mag_w;

    // ring entries of a channel that has not wrapped yet hold nothing
    assign old_sq        = r_cur.wrap ? r_ring_rd : '0;
    assign new_sum       = r_cur.sum - SUM_W'(old_sq) + SUM_W'(r_sq);
    assign last_pos      = (32'(r_cur.pos) == WINDOW_LEN - 1);
    assign upd_st.wrap   = r_cur.wrap | last_pos;
    assign upd_st.pos    = last_pos ? '0 : POS_W'(r_cur.pos + POS_W'(1));
    assign upd_st.sum    = new_sum;

    // largest root with WINDOW_LEN * root^2 <= sum, one root bit a cycle;
    // r_e holds sum - W*r^2, r_a holds W*r << (b+1), r_b holds W << 2b
    assign sq_trial      = r_a + r_b;
    assign sq_ge         = (sq_trial <= D_W'(r_e));
    assign sq_acc        = sq_trial + r_b;

    assign root_ext      = RTX_W'(r_root);
    assign rms           = (|(root_ext >> mwrms_pkg::RMS_W)) ? '1
                                                             : root_ext[mwrms_pkg::RMS_W-1:0];

    assign out_free      = !r_out_vld || i_out_ready;
    assign out_load      = (r_state == mwrms_pkg::ST_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mwrms_pkg::ST_IDLE: begin
                if (in_acc && ch_ok) begin
                    n_state = mwrms_pkg::ST_READ;
                end
            end
            mwrms_pkg::ST_READ: begin
                n_state = mwrms_pkg::ST_UPDATE;
            end
            mwrms_pkg::ST_UPDATE: begin
                n_state = mwrms_pkg::ST_SQRT;
            end
            mwrms_pkg::ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = mwrms_pkg::ST_DONE;
                end
            end
            mwrms_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = mwrms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwrms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwrms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_state == mwrms_pkg::ST_UPDATE) begin
                r_chan_vld[cur_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // memories: channel records and square ring
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cst_rd <= r_chan_mem[in_idx];
        end
        if (r_state == mwrms_pkg::ST_UPDATE) begin
            r_chan_mem[cur_idx] <= upd_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mwrms_pkg::ST_READ) begin
            r_ring_rd <= r_ring[ring_addr];
        end
        if (r_state == mwrms_pkg::ST_UPDATE) begin
            r_ring[r_addr] <= r_sq;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mwrms_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_ch  <= i_channel;
                    r_mag <= mag;
                end
            end
            mwrms_pkg::ST_READ: begin
                r_cur  <= cst;
                r_addr <= ring_addr;
                r_sq   <= prod[SQ_W-1:0];
            end
            mwrms_pkg::ST_UPDATE: begin
                r_e    <= new_sum;
                r_a    <= '0;
                r_b    <= B_INIT;
                r_root <= '0;
                r_cnt  <= CNT_W'(RT_W);
            end
            mwrms_pkg::ST_SQRT: begin
                if (r_cnt != '0) begin
                    if (sq_ge) begin
                        r_e <= r_e - sq_trial[SUM_W-1:0];
                        r_a <= sq_acc >> 1;
                    end else begin
                        r_a <= r_a >> 1;
                    end
                    r_b    <= r_b >> 2;
                    r_root <= {r_root[RT_W-2:0], sq_ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_ch  <= r_ch;
            r_out_rms <= rms;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_channel = r_out_ch;
    assign o_rms_value   = r_out_rms;

endmodule
